>>> design/rau_pkg.sv
// Shared types and constants for the rational arithmetic unit.
package rau_pkg;

	localparam int WIDTH_DEF = 32;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STS_OK       = 2'd0,
		STS_OPND_DEN = 2'd1,
		STS_RES_DEN  = 2'd2
	} sts_t;

	typedef enum logic [3:0] {
		R_AN, R_AD, R_BN, R_BD, R_X, R_Y, R_T, R_NUM, R_DEN
	} reg_sel_t;

	typedef enum logic [3:0] {
		DP_NOP, DP_LOAD, DP_MUL, DP_DIV, DP_MOV, DP_ABS, DP_ADD, DP_SUB, DP_ORDER, DP_RESULT
	} dp_op_t;

	typedef struct packed {
		logic     valid;
		dp_op_t   op;
		reg_sel_t src_a;
		reg_sel_t src_b;
		reg_sel_t dst;
		logic     rem_sel;
		sts_t     res_sts;
	} dp_cmd_t;

	typedef struct packed {
		logic ack;
		logic ad_zero;
		logic bd_zero;
		logic y_zero;
		logic den_zero;
		op_t  op;
	} dp_stat_t;

endpackage

>>> design/rau_mul.sv
// Shift-and-add multiplier, one multiplier bit per cycle, low WIDTH bits kept.
module rau_mul #(
	parameter int WIDTH = rau_pkg::WIDTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [WIDTH-1:0] a,
	input  logic [WIDTH-1:0] b,
	output logic             done,
	output logic [WIDTH-1:0] p
);
	import rau_pkg::*;

	localparam int CW = $clog2(WIDTH);

	logic [WIDTH-1:0] a_q, b_q, acc_q, acc_nxt;
	logic [CW-1:0]    cnt_q;
	logic             run_q, done_q;

	assign acc_nxt = acc_q + (b_q[0] ? a_q : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= run_q && !start && (cnt_q == CW'(WIDTH - 1));
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(WIDTH - 1))
					run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (run_q) begin
			acc_q <= acc_nxt;
			a_q   <= {a_q[WIDTH-2:0], 1'b0};
			b_q   <= {1'b0, b_q[WIDTH-1:1]};
		end
	end

	assign done = done_q;
	assign p    = acc_q;

endmodule

>>> design/rau_div.sv
// Restoring signed divider, truncating quotient and remainder, one bit per cycle.
module rau_div #(
	parameter int WIDTH = rau_pkg::WIDTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [WIDTH-1:0] a,
	input  logic [WIDTH-1:0] b,
	output logic             done,
	output logic [WIDTH-1:0] q,
	output logic [WIDTH-1:0] r
);
	import rau_pkg::*;

	localparam int CW = $clog2(WIDTH);

	logic [WIDTH-1:0] dvd_q, dvs_q, rem_q;
	logic [WIDTH:0]   r_sh;
	logic [WIDTH+1:0] diff;
	logic             negq_q, negr_q;
	logic [CW-1:0]    cnt_q;
	logic             run_q, done_q;

	assign r_sh = {rem_q, dvd_q[WIDTH-1]};
	assign diff = {1'b0, r_sh} - {2'b00, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= run_q && !start && (cnt_q == CW'(WIDTH - 1));
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(WIDTH - 1))
					run_q <= 1'b0;
			end
		end
	end

	// magnitudes as unsigned; the most negative value maps to 2^(WIDTH-1)
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q  <= a[WIDTH-1] ? -a : a;
			dvs_q  <= b[WIDTH-1] ? -b : b;
			rem_q  <= '0;
			negq_q <= a[WIDTH-1] ^ b[WIDTH-1];
			negr_q <= a[WIDTH-1];
		end else if (run_q) begin
			rem_q <= diff[WIDTH+1] ? r_sh[WIDTH-1:0] : diff[WIDTH-1:0];
			dvd_q <= {dvd_q[WIDTH-2:0], ~diff[WIDTH+1]};
		end
	end

	assign done = done_q;
	assign q    = negq_q ? -dvd_q : dvd_q;
	assign r    = negr_q ? -rem_q : rem_q;

endmodule

>>> design/rau_dp.sv
// Datapath: operand registers, multiplier and divider, result registers.
module rau_dp #(
	parameter int WIDTH = rau_pkg::WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  rau_pkg::dp_cmd_t   dcmd,
	output rau_pkg::dp_stat_t  stat,
	input  logic [1:0]         cmd,
	input  logic [31:0]        a_num,
	input  logic [31:0]        a_den,
	input  logic [31:0]        b_num,
	input  logic [31:0]        b_den,
	output logic [31:0]        res_num,
	output logic [31:0]        res_den,
	output logic [1:0]         status,
	output logic               done
);
	import rau_pkg::*;

	logic [WIDTH-1:0] an_q, ad_q, bn_q, bd_q, x_q, y_q, t_q, num_q, den_q;
	logic [WIDTH-1:0] opa, opb, wr_data, mul_p, div_q, div_r;
	logic [31:0]      rnum_q, rden_q;
	sts_t             sts_q;
	op_t              op_q;
	reg_sel_t         dst_q, wr_sel;
	logic             rem_sel_q, wr_en, mul_start, div_start, mul_done, div_done;
	logic             ack_q, done_q;

	function automatic logic [WIDTH-1:0] ext_in(input logic [31:0] v);
		logic [63:0] e;
		e = {{32{v[31]}}, v};
		return e[WIDTH-1:0];
	endfunction

	function automatic logic [31:0] ext_out(input logic [WIDTH-1:0] v);
		logic [127:0] e;
		e = {{(128-WIDTH){v[WIDTH-1]}}, v};
		return e[31:0];
	endfunction

	always_comb begin
		case (dcmd.src_a)
			R_AN:    opa = an_q;
			R_AD:    opa = ad_q;
			R_BN:    opa = bn_q;
			R_BD:    opa = bd_q;
			R_X:     opa = x_q;
			R_Y:     opa = y_q;
			R_T:     opa = t_q;
			R_NUM:   opa = num_q;
			R_DEN:   opa = den_q;
			default: opa = '0;
		endcase
		case (dcmd.src_b)
			R_AN:    opb = an_q;
			R_AD:    opb = ad_q;
			R_BN:    opb = bn_q;
			R_BD:    opb = bd_q;
			R_X:     opb = x_q;
			R_Y:     opb = y_q;
			R_T:     opb = t_q;
			R_NUM:   opb = num_q;
			R_DEN:   opb = den_q;
			default: opb = '0;
		endcase
	end

	assign mul_start = dcmd.valid && (dcmd.op == DP_MUL);
	assign div_start = dcmd.valid && (dcmd.op == DP_DIV);

	rau_mul #(.WIDTH(WIDTH)) u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start), .a(opa), .b(opb),
		.done(mul_done), .p(mul_p)
	);

	rau_div #(.WIDTH(WIDTH)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .a(opa), .b(opb),
		.done(div_done), .q(div_q), .r(div_r)
	);

	always_comb begin
		wr_en   = 1'b0;
		wr_sel  = dcmd.dst;
		wr_data = opa;
		if (mul_done) begin
			wr_en   = 1'b1;
			wr_sel  = dst_q;
			wr_data = mul_p;
		end else if (div_done) begin
			wr_en   = 1'b1;
			wr_sel  = dst_q;
			wr_data = rem_sel_q ? div_r : div_q;
		end else if (dcmd.valid) begin
			case (dcmd.op)
				DP_MOV: wr_en = 1'b1;
				DP_ABS: begin
					wr_en   = 1'b1;
					wr_data = opa[WIDTH-1] ? -opa : opa;
				end
				DP_ADD: begin
					wr_en   = 1'b1;
					wr_data = opa + opb;
				end
				DP_SUB: begin
					wr_en   = 1'b1;
					wr_data = opa - opb;
				end
				default: wr_en = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ack_q  <= 1'b0;
			done_q <= 1'b0;
			op_q   <= OP_ADD;
		end else begin
			ack_q  <= mul_done || div_done ||
			          (dcmd.valid && dcmd.op != DP_MUL && dcmd.op != DP_DIV &&
			           dcmd.op != DP_NOP);
			done_q <= dcmd.valid && (dcmd.op == DP_RESULT);
			if (load)
				op_q <= op_t'(cmd);
		end
	end

	always_ff @(posedge clk) begin
		if (mul_start || div_start) begin
			dst_q     <= dcmd.dst;
			rem_sel_q <= dcmd.rem_sel;
		end
		// operands are captured at the accepting edge
		if (load) begin
			an_q <= ext_in(a_num);
			ad_q <= ext_in(a_den);
			bn_q <= ext_in(b_num);
			bd_q <= ext_in(b_den);
		end
		// Euclid set-up: larger (signed) operand goes to x
		if (dcmd.valid && dcmd.op == DP_ORDER) begin
			if ($signed(opa) < $signed(opb)) begin
				x_q <= opb;
				y_q <= opa;
			end else begin
				x_q <= opa;
				y_q <= opb;
			end
		end
		if (wr_en) begin
			case (wr_sel)
				R_AN:    an_q  <= wr_data;
				R_AD:    ad_q  <= wr_data;
				R_BN:    bn_q  <= wr_data;
				R_BD:    bd_q  <= wr_data;
				R_X:     x_q   <= wr_data;
				R_Y:     y_q   <= wr_data;
				R_T:     t_q   <= wr_data;
				R_NUM:   num_q <= wr_data;
				R_DEN:   den_q <= wr_data;
				default: t_q   <= t_q;
			endcase
		end
		if (dcmd.valid && dcmd.op == DP_RESULT) begin
			sts_q <= dcmd.res_sts;
			if (dcmd.res_sts == STS_OK) begin
				rnum_q <= ext_out(num_q);
				rden_q <= ext_out(den_q);
			end else begin
				rnum_q <= '0;
				rden_q <= '0;
			end
		end
	end

	assign stat.ack      = ack_q;
	assign stat.ad_zero  = (ad_q == '0);
	assign stat.bd_zero  = (bd_q == '0);
	assign stat.y_zero   = (y_q == '0);
	assign stat.den_zero = (den_q == '0);
	assign stat.op       = op_q;

	assign res_num = rnum_q;
	assign res_den = rden_q;
	assign status  = sts_q;
	assign done    = done_q;

endmodule

>>> design/rau_ctrl.sv
// Controller: sequences datapath operations for one transaction.
module rau_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              simplify,
	input  rau_pkg::dp_stat_t stat,
	output rau_pkg::dp_cmd_t  dcmd,
	output logic              load,
	output logic              busy
);
	import rau_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE, ST_LOAD, ST_ORD, ST_EU_REM, ST_EU_MX, ST_EU_MY, ST_EU_ABS,
		ST_LCM_P, ST_LCM_Q, ST_LCM_A, ST_SC_A, ST_MUL_A, ST_SC_B, ST_MUL_B,
		ST_COMB, ST_PROD_N, ST_PROD_D, ST_SIM_N, ST_SIM_D, ST_ERR1, ST_ERR2, ST_OUT
	} state_t;

	state_t   state_q, next_d, chk_d;
	dp_cmd_t  cmd_q, cmd_d;
	logic     pend_q, second_q;
	logic     set_second;
	reg_sel_t g_a, g_b;

	// second pass of Euclid reduces the result instead of the denominators
	assign g_a = second_q ? R_NUM : R_AD;
	assign g_b = second_q ? R_DEN : R_BD;

	always_comb begin
		chk_d      = ST_OUT;
		set_second = 1'b0;
		if (stat.den_zero)
			chk_d = ST_ERR2;
		else if (simplify) begin
			chk_d      = ST_ORD;
			set_second = 1'b1;
		end
	end

	always_comb begin
		cmd_d         = '0;
		cmd_d.valid   = 1'b1;
		cmd_d.op      = DP_NOP;
		cmd_d.src_a   = R_AN;
		cmd_d.src_b   = R_AN;
		cmd_d.dst     = R_T;
		cmd_d.rem_sel = 1'b0;
		cmd_d.res_sts = STS_OK;
		next_d        = ST_IDLE;
		case (state_q)
			ST_LOAD: begin
				cmd_d.op = DP_LOAD;
				if (stat.ad_zero || stat.bd_zero)
					next_d = ST_ERR1;
				else if (stat.op == OP_ADD || stat.op == OP_SUB)
					next_d = ST_ORD;
				else
					next_d = ST_PROD_N;
			end
			ST_ORD: begin
				cmd_d.op    = DP_ORDER;
				cmd_d.src_a = g_a;
				cmd_d.src_b = g_b;
				next_d      = stat.y_zero ? ST_EU_ABS : ST_EU_REM;
			end
			ST_EU_REM: begin
				cmd_d.op      = DP_DIV;
				cmd_d.src_a   = R_X;
				cmd_d.src_b   = R_Y;
				cmd_d.dst     = R_T;
				cmd_d.rem_sel = 1'b1;
				next_d        = ST_EU_MX;
			end
			ST_EU_MX: begin
				cmd_d.op    = DP_MOV;
				cmd_d.src_a = R_Y;
				cmd_d.dst   = R_X;
				next_d      = ST_EU_MY;
			end
			ST_EU_MY: begin
				cmd_d.op    = DP_MOV;
				cmd_d.src_a = R_T;
				cmd_d.dst   = R_Y;
				next_d      = stat.y_zero ? ST_EU_ABS : ST_EU_REM;
			end
			ST_EU_ABS: begin
				cmd_d.op    = DP_ABS;
				cmd_d.src_a = R_X;
				cmd_d.dst   = R_T;
				next_d      = second_q ? ST_SIM_N : ST_LCM_P;
			end
			ST_LCM_P: begin
				cmd_d.op    = DP_MUL;
				cmd_d.src_a = R_AD;
				cmd_d.src_b = R_BD;
				cmd_d.dst   = R_X;
				next_d      = ST_LCM_Q;
			end
			ST_LCM_Q: begin
				cmd_d.op    = DP_DIV;
				cmd_d.src_a = R_X;
				cmd_d.src_b = R_T;
				cmd_d.dst   = R_X;
				next_d      = ST_LCM_A;
			end
			ST_LCM_A: begin
				cmd_d.op    = DP_ABS;
				cmd_d.src_a = R_X;
				cmd_d.dst   = R_DEN;
				next_d      = ST_SC_A;
			end
			ST_SC_A: begin
				cmd_d.op    = DP_DIV;
				cmd_d.src_a = R_DEN;
				cmd_d.src_b = R_AD;
				cmd_d.dst   = R_T;
				next_d      = ST_MUL_A;
			end
			ST_MUL_A: begin
				cmd_d.op    = DP_MUL;
				cmd_d.src_a = R_AN;
				cmd_d.src_b = R_T;
				cmd_d.dst   = R_NUM;
				next_d      = ST_SC_B;
			end
			ST_SC_B: begin
				cmd_d.op    = DP_DIV;
				cmd_d.src_a = R_DEN;
				cmd_d.src_b = R_BD;
				cmd_d.dst   = R_T;
				next_d      = ST_MUL_B;
			end
			ST_MUL_B: begin
				cmd_d.op    = DP_MUL;
				cmd_d.src_a = R_BN;
				cmd_d.src_b = R_T;
				cmd_d.dst   = R_X;
				next_d      = ST_COMB;
			end
			ST_COMB: begin
				cmd_d.op    = (stat.op == OP_SUB) ? DP_SUB : DP_ADD;
				cmd_d.src_a = R_NUM;
				cmd_d.src_b = R_X;
				cmd_d.dst   = R_NUM;
				next_d      = chk_d;
			end
			ST_PROD_N: begin
				cmd_d.op    = DP_MUL;
				cmd_d.src_a = R_AN;
				cmd_d.src_b = (stat.op == OP_DIV) ? R_BD : R_BN;
				cmd_d.dst   = R_NUM;
				next_d      = ST_PROD_D;
			end
			ST_PROD_D: begin
				cmd_d.op    = DP_MUL;
				cmd_d.src_a = R_AD;
				cmd_d.src_b = (stat.op == OP_DIV) ? R_BN : R_BD;
				cmd_d.dst   = R_DEN;
				next_d      = chk_d;
			end
			ST_SIM_N: begin
				cmd_d.op    = DP_DIV;
				cmd_d.src_a = R_NUM;
				cmd_d.src_b = R_T;
				cmd_d.dst   = R_NUM;
				next_d      = ST_SIM_D;
			end
			ST_SIM_D: begin
				cmd_d.op    = DP_DIV;
				cmd_d.src_a = R_DEN;
				cmd_d.src_b = R_T;
				cmd_d.dst   = R_DEN;
				next_d      = ST_OUT;
			end
			ST_ERR1: begin
				cmd_d.op      = DP_RESULT;
				cmd_d.res_sts = STS_OPND_DEN;
			end
			ST_ERR2: begin
				cmd_d.op      = DP_RESULT;
				cmd_d.res_sts = STS_RES_DEN;
			end
			ST_OUT: cmd_d.op = DP_RESULT;
			default: begin
				cmd_d.valid = 1'b0;
				next_d      = ST_IDLE;
			end
		endcase
	end

	// each step: issue one command, then wait for the datapath to acknowledge
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cmd_q    <= '0;
			pend_q   <= 1'b0;
			second_q <= 1'b0;
		end else begin
			if (state_q == ST_IDLE) begin
				cmd_q.valid <= 1'b0;
				pend_q      <= 1'b0;
				if (start) begin
					state_q  <= ST_LOAD;
					second_q <= 1'b0;
				end
			end else if (!pend_q) begin
				cmd_q  <= cmd_d;
				pend_q <= 1'b1;
			end else begin
				cmd_q.valid <= 1'b0;
				if (stat.ack) begin
					pend_q  <= 1'b0;
					state_q <= next_d;
					if (set_second && (state_q == ST_COMB || state_q == ST_PROD_D))
						second_q <= 1'b1;
				end
			end
		end
	end

	assign dcmd = cmd_q;
	assign load = (state_q == ST_IDLE) && start;
	assign busy = (state_q != ST_IDLE);

endmodule

>>> design/rational_arithmetic_unit_top.sv
// Top level of the rational arithmetic unit.
//
// Adds, subtracts, multiplies or divides two signed fractions, optionally
// reducing the result by the gcd of numerator and denominator.
// Command channel: a transaction is taken when start is high and busy is low;
// cmd, a_num, a_den, b_num, b_den are sampled then. busy stays high until the
// result has been issued; only one transaction is in flight.
// Result channel: res_num, res_den and status are valid for the single cycle
// in which done is high. The receiver cannot stall; it must take it then.
// Configuration: simplify_enable is written when cfg_valid and cfg_ready are
// both high; cfg_ready is always high. Write it only while busy is low.
// Steps: a simple datapath step is issued, executed and acknowledged; a multiply
// or divide step runs in the shift-add multiplier or the restoring divider.
// Unreduced multiply/divide runs two multiply steps. Each Euclid remainder step
// is a divide and two moves, plus ordering and absolute value steps per pass;
// reduction adds a gcd pass and two divides. Add/subtract run a gcd pass, six
// multiply/divide steps and a combine step. busy drops the cycle after done.
// Reset (arst_n low) returns the controller to idle and sets simplify_enable.
module rational_arithmetic_unit_top #(
	parameter int WIDTH = rau_pkg::WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  cmd,
	input  logic [31:0] a_num,
	input  logic [31:0] a_den,
	input  logic [31:0] b_num,
	input  logic [31:0] b_den,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        simplify_enable,
	output logic        done,
	output logic [31:0] res_num,
	output logic [31:0] res_den,
	output logic [1:0]  status
);
	import rau_pkg::*;

	dp_cmd_t  dcmd;
	dp_stat_t stat;
	logic     simplify_q;
	logic     load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			simplify_q <= 1'b1;
		else if (cfg_valid && cfg_ready)
			simplify_q <= simplify_enable;
	end

	assign cfg_ready = 1'b1;

	rau_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .simplify(simplify_q),
		.stat(stat), .dcmd(dcmd), .load(load), .busy(busy)
	);

	rau_dp #(.WIDTH(WIDTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .load(load), .dcmd(dcmd), .stat(stat), .cmd(cmd),
		.a_num(a_num), .a_den(a_den), .b_num(b_num), .b_den(b_den),
		.res_num(res_num), .res_den(res_den), .status(status), .done(done)
	);

endmodule
